### src/bclru_pkg.sv
// Shared constants, types and helpers for the block cache tag engine.
// No dependencies; the interfaces, the core and the bench use this package.
`default_nettype none

package bclru_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int MODE_W  = 2;
  localparam int BLK_W   = 32;
  localparam int KIND_W  = 2;
  localparam int WAY_W   = 4;
  localparam int SECT_W  = 32;
  localparam int SPB_W   = 8;
  localparam int STAMP_W = 32;
  localparam int PROD_W  = BLK_W + SPB_W;

  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WB   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL = 2'd2;

  localparam logic [SPB_W-1:0] SPB_RESET = 8'd8;
  localparam logic [SPB_W-1:0] SPB_MIN   = 8'd1;
  localparam logic [SPB_W-1:0] SPB_MAX   = 8'd128;

  typedef logic [IDX_W-1:0] idx_t;

  // One line of the tag memory.
  typedef struct packed {
    logic [BLK_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  // Reduce an entry index to the way field, modulo 16.
  function automatic logic [WAY_W-1:0] to_way(idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[WAY_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/bclru_if.sv
// Valid/ready channel interfaces: request, response and block size register.
// Depends on bclru_pkg for field widths.
`default_nettype none

interface bclru_req_if;
  logic                         valid;
  logic                         ready;
  logic [bclru_pkg::MODE_W-1:0] mode;
  logic [bclru_pkg::BLK_W-1:0]  block_number;

  modport source (output valid, mode, block_number, input ready);
  modport sink   (input valid, mode, block_number, output ready);
endinterface

interface bclru_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bclru_pkg::KIND_W-1:0] kind;
  logic [bclru_pkg::WAY_W-1:0]  way;
  logic [bclru_pkg::SECT_W-1:0] base_sector;
  logic [bclru_pkg::SPB_W-1:0]  sector_count;
  logic                         hit;
  logic                         last;

  modport source (output valid, kind, way, base_sector, sector_count, hit, last,
                  input ready);
  modport sink   (input valid, kind, way, base_sector, sector_count, hit, last,
                  output ready);
endinterface

interface bclru_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bclru_pkg::SPB_W-1:0] blk_sectors;

  modport source (output valid, blk_sectors, input ready);
  modport sink   (input valid, blk_sectors, output ready);
endinterface

`default_nettype wire

### src/block_cache_lru_writeback_tags_core.sv
// Block cache tag engine: fully associative, LRU victim, write-back.
// Access: a tag scan over all ENTRIES (one memory read per cycle), a decide
// step, then each result (hit 1, miss 1 to 3) as rsp is free.
// Flush: steps through the entries, held while a write-back waits for rsp, then the completion.
// One request in flight; rst (synchronous) clears valid/dirty bits, the clock.
// Depends on bclru_pkg, bclru_if and bclru_ram.
`default_nettype none

module block_cache_lru_writeback_tags_core (
  input  logic         clk,
  input  logic         rst,
  bclru_req_if.sink    req,
  bclru_rsp_if.source  rsp,
  bclru_cfg_if.sink    cfg
);
  import bclru_pkg::*;

  localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WB,
    S_FILL,
    S_DONE,
    S_FLUSH
  } state_t;

  state_t state;

  // Per-entry flags live in flops so reset clears them at once; tags and
  // stamps live in the memory and are only trusted where valid is set.
  logic [ENTRIES-1:0] vld;
  logic [ENTRIES-1:0] drt;

  logic [STAMP_W-1:0] acc_clock;
  logic [SPB_W-1:0]   spb_reg;
  logic [SPB_W-1:0]   spb_eff;

  // Request context.
  logic [MODE_W-1:0]  mode_r;
  logic [BLK_W-1:0]   blk;
  logic               acc_r;
  logic               hit_r;
  idx_t               way_r;

  // Scan bookkeeping.
  idx_t               pidx;
  idx_t               pidx_next;
  logic               found;
  idx_t               fidx;
  logic               have_inv;
  idx_t               inv_idx;
  idx_t               min_idx;
  logic [STAMP_W-1:0] min_stamp;
  logic [BLK_W-1:0]   min_tag;
  idx_t               victim;

  // Tag memory ports.
  logic  ram_we;
  idx_t  ram_waddr;
  line_t ram_wdata;
  idx_t  ram_raddr;
  line_t ram_rdata;

  // Response register and emit path.
  logic               rsp_valid;
  logic               out_free;
  logic               cur_wb;
  logic               flush_adv;
  logic               emit_en;
  logic [KIND_W-1:0]  emit_kind;
  idx_t               emit_way;
  logic [BLK_W-1:0]   emit_op;
  logic               emit_hit;
  logic               emit_last;
  logic [PROD_W-1:0]  prod;

  bclru_ram #(
    .WIDTH (LINE_W),
    .DEPTH (ENTRIES)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clamp the block size register into 1..128.
  always_comb begin
    if (spb_reg == '0) begin
      spb_eff = SPB_MIN;
    end else if (spb_reg > SPB_MAX) begin
      spb_eff = SPB_MAX;
    end else begin
      spb_eff = spb_reg;
    end
  end

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign pidx_next = (pidx == LAST_IDX) ? '0 : pidx + idx_t'(1);
  assign victim    = have_inv ? inv_idx : min_idx;

  // Response slot is free when empty or being drained this cycle.
  assign out_free  = !rsp_valid || rsp.ready;
  // Flush entry under inspection needs a write-back.
  assign cur_wb    = vld[pidx] && drt[pidx];
  // Flush advances past clean entries at once, past dirty ones on transfer.
  assign flush_adv = !cur_wb || out_free;

  // Read address: entry 0 on accept, then step one entry per cycle. During a
  // stalled flush write-back keep re-reading the same entry to hold its tag.
  always_comb begin
    unique case (state)
      S_SCAN:  ram_raddr = pidx_next;
      S_FLUSH: ram_raddr = flush_adv ? pidx_next : pidx;
      default: ram_raddr = '0;
    endcase
  end

  // Write back tag and stamp once the scan has settled: refresh on hit,
  // replace the victim on miss. No read overlaps this write.
  always_comb begin
    ram_we          = (state == S_DECIDE);
    ram_waddr       = found ? fidx : victim;
    ram_wdata.tag   = blk;
    ram_wdata.stamp = acc_clock;
  end

  // Select what goes into the response register this cycle.
  always_comb begin
    emit_kind = KIND_DONE;
    emit_way  = way_r;
    emit_op   = '0;
    emit_hit  = 1'b0;
    emit_last = 1'b0;
    unique case (state)
      S_WB: begin
        emit_kind = KIND_WB;
        emit_op   = min_tag;
      end
      S_FILL: begin
        emit_kind = KIND_FILL;
        emit_op   = blk;
      end
      S_DONE: begin
        emit_kind = KIND_DONE;
        emit_op   = acc_r ? blk : '0;
        emit_hit  = hit_r;
        emit_last = 1'b1;
      end
      S_FLUSH: begin
        emit_kind = KIND_WB;
        emit_way  = pidx;
        emit_op   = ram_rdata.tag;
      end
      default: begin
        emit_kind = KIND_DONE;
      end
    endcase
    emit_en = out_free && ((state == S_WB) || (state == S_FILL) ||
                           (state == S_DONE) || ((state == S_FLUSH) && cur_wb));
  end

  // First sector: block times block size, wrapping at 32 bits.
  assign prod = {{SPB_W{1'b0}}, emit_op} * {{BLK_W{1'b0}}, spb_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      vld       <= '0;
      drt       <= '0;
      acc_clock <= '0;
      spb_reg   <= SPB_RESET;
    end else begin
      if (cfg.valid) begin
        spb_reg <= cfg.blk_sectors;
      end

      // Load the response register, or drop it once transferred.
      if (emit_en) begin
        rsp_valid        <= 1'b1;
        rsp.kind         <= emit_kind;
        rsp.way          <= to_way(emit_way);
        rsp.base_sector  <= prod[SECT_W-1:0];
        rsp.sector_count <= spb_eff;
        rsp.hit          <= emit_hit;
        rsp.last         <= emit_last;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode_r   <= req.mode;
            blk      <= req.block_number;
            pidx     <= '0;
            way_r    <= '0;
            hit_r    <= 1'b0;
            found    <= 1'b0;
            have_inv <= 1'b0;
            if (req.mode == MODE_FLUSH) begin
              acc_r <= 1'b0;
              state <= S_FLUSH;
            end else if ((req.mode == MODE_READ) || (req.mode == MODE_WRITE)) begin
              acc_r     <= 1'b1;
              acc_clock <= acc_clock + STAMP_W'(1);
              state     <= S_SCAN;
            end else begin
              // Unused mode: completion only.
              acc_r <= 1'b0;
              state <= S_DONE;
            end
          end
        end

        S_SCAN: begin
          if (vld[pidx] && (ram_rdata.tag == blk) && !found) begin
            found <= 1'b1;
            fidx  <= pidx;
          end
          if (!vld[pidx] && !have_inv) begin
            have_inv <= 1'b1;
            inv_idx  <= pidx;
          end
          // Strict compare keeps the first entry of smallest stamp.
          if ((pidx == '0) || (ram_rdata.stamp < min_stamp)) begin
            min_stamp <= ram_rdata.stamp;
            min_idx   <= pidx;
            min_tag   <= ram_rdata.tag;
          end
          if (pidx == LAST_IDX) begin
            state <= S_DECIDE;
          end else begin
            pidx <= pidx_next;
          end
        end

        S_DECIDE: begin
          if (found) begin
            way_r <= fidx;
            hit_r <= 1'b1;
            if (mode_r == MODE_WRITE) begin
              drt[fidx] <= 1'b1;
            end
            state <= S_DONE;
          end else begin
            way_r       <= victim;
            vld[victim] <= 1'b1;
            drt[victim] <= (mode_r == MODE_WRITE);
            // A valid victim means no free entry, so it is the LRU entry
            // whose tag was captured during the scan.
            if (vld[victim] && drt[victim]) begin
              state <= S_WB;
            end else if (mode_r == MODE_READ) begin
              state <= S_FILL;
            end else begin
              state <= S_DONE;
            end
          end
        end

        S_WB: begin
          if (out_free) begin
            state <= (mode_r == MODE_READ) ? S_FILL : S_DONE;
          end
        end

        S_FILL: begin
          if (out_free) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        S_FLUSH: begin
          if (flush_adv) begin
            if (cur_wb) begin
              drt[pidx] <= 1'b0;
            end
            if (pidx == LAST_IDX) begin
              state <= S_DONE;
            end else begin
              pidx <= pidx_next;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire

### src/bclru_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module bclru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### verif/block_cache_lru_writeback_tags_core_test.sv
// Self-checking bench for the block cache tag engine: random and directed accesses and
// flushes under bursty requests, response stalls and block size changes.
// Depends on bclru_pkg, the bclru_if channel interfaces and block_cache_lru_writeback_tags_core.
`timescale 1ns / 100ps

module block_cache_lru_writeback_tags_core_test;
  import bclru_pkg::*;

  // Mode 3 is not a real operation; the engine answers with a bare completion.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int POOL_SIZE = 24;
  localparam int PHASE_ITEMS = 43;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BLK_W-1:0]  block_number;
  } cache_access_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WAY_W-1:0]  way;
    logic [SECT_W-1:0] base_sector;
    logic [SPB_W-1:0]  sector_count;
    logic              hit;
    logic              last;
  } cache_result_t;

  logic clk;
  logic rst;

  bclru_req_if req_ch ();
  bclru_rsp_if rsp_ch ();
  bclru_cfg_if cfg_ch ();

  block_cache_lru_writeback_tags_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // 10 ns clock, high phase first.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the tag engine: tags, valid/dirty bits, LRU stamps, access clock
  // and the block size register as the engine last took it.
  // ---------------------------------------------------------------------------
  logic [BLK_W-1:0]   line_tag   [ENTRIES];
  logic               line_valid [ENTRIES];
  logic               line_dirty [ENTRIES];
  logic [STAMP_W-1:0] line_stamp [ENTRIES];
  logic [STAMP_W-1:0] access_tick;
  logic [SPB_W-1:0]   spb_shadow;

  cache_result_t pending_results[$];
  cache_access_t access_queue[$];

  int mismatch_count = 0;
  int items_queued = 0;
  int items_taken = 0;
  int results_seen = 0;
  int n_reads = 0, n_writes = 0, n_flushes = 0, n_spare = 0;
  int n_hits = 0, n_writebacks = 0, n_fills = 0, n_sizes = 1;

  logic [BLK_W-1:0] block_pool [POOL_SIZE];

  function automatic logic [SECT_W-1:0] first_sector(logic [BLK_W-1:0] blk,
                                                     logic [SPB_W-1:0] eff);
    logic [SECT_W-1:0] prod;
    prod = blk * 32'(eff);  // wraps at 32 bits
    return prod;
  endfunction

  function automatic void push_result(logic [KIND_W-1:0] kind, int idx,
                                      logic [SECT_W-1:0] start, logic [SPB_W-1:0] count,
                                      logic hit, logic last);
    cache_result_t r;
    r.kind         = kind;
    r.way          = WAY_W'(idx);
    r.base_sector  = start;
    r.sector_count = count;
    r.hit          = hit;
    r.last         = last;
    pending_results.push_back(r);
    if (kind == KIND_WB) n_writebacks++;
    if (kind == KIND_FILL) n_fills++;
  endfunction

  // Work out every result one accepted access causes, and update the shadow.
  function automatic void predict_access(logic [MODE_W-1:0] mode, logic [BLK_W-1:0] blk);
    logic [SPB_W-1:0] eff;
    int victim;
    eff = (spb_shadow == 8'd0) ? SPB_MIN : (spb_shadow > SPB_MAX) ? SPB_MAX : spb_shadow;
    case (mode)
      MODE_FLUSH: begin
        n_flushes++;
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i] && line_dirty[i]) begin
            push_result(KIND_WB, i, first_sector(line_tag[i], eff), eff, 1'b0, 1'b0);
            line_dirty[i] = 1'b0;
          end
        end
        push_result(KIND_DONE, 0, '0, eff, 1'b0, 1'b1);
      end
      MODE_SPARE: begin
        n_spare++;
        push_result(KIND_DONE, 0, '0, eff, 1'b0, 1'b1);
      end
      default: begin
        if (mode == MODE_READ) n_reads++;
        else n_writes++;
        access_tick = access_tick + STAMP_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i] && line_tag[i] == blk) begin
            line_stamp[i] = access_tick;
            if (mode == MODE_WRITE) line_dirty[i] = 1'b1;
            n_hits++;
            push_result(KIND_DONE, i, first_sector(blk, eff), eff, 1'b1, 1'b1);
            return;
          end
        end
        // Victim: first free line, else first line holding the oldest stamp.
        victim = -1;
        for (int i = 0; i < ENTRIES && victim < 0; i++) begin
          if (!line_valid[i]) victim = i;
        end
        if (victim < 0) begin
          victim = 0;
          for (int i = 1; i < ENTRIES; i++) begin
            if (line_stamp[i] < line_stamp[victim]) victim = i;
          end
        end
        if (line_valid[victim] && line_dirty[victim])
          push_result(KIND_WB, victim, first_sector(line_tag[victim], eff), eff, 1'b0, 1'b0);
        if (mode == MODE_READ)
          push_result(KIND_FILL, victim, first_sector(blk, eff), eff, 1'b0, 1'b0);
        line_tag[victim]   = blk;
        line_stamp[victim] = access_tick;
        line_valid[victim] = 1'b1;
        line_dirty[victim] = (mode == MODE_WRITE);
        push_result(KIND_DONE, victim, first_sector(blk, eff), eff, 1'b0, 1'b1);
      end
    endcase
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 40)
      $display("[%0t] mismatch on result %0d: %s got 0x%0h want 0x%0h",
               $time, results_seen, field, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge. Predict on every
  // accepted request; check every accepted response against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  logic req_fired;

  always @(posedge clk) begin
    cache_result_t want;
    if (rst) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        predict_access(req_ch.mode, req_ch.block_number);
        items_taken++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", {30'd0, rsp_ch.kind}, 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.kind !== want.kind)
            report("kind", 32'(rsp_ch.kind), 32'(want.kind));
          if (rsp_ch.way !== want.way)
            report("way", 32'(rsp_ch.way), 32'(want.way));
          if (rsp_ch.base_sector !== want.base_sector)
            report("base_sector", rsp_ch.base_sector, want.base_sector);
          if (rsp_ch.sector_count !== want.sector_count)
            report("sector_count", 32'(rsp_ch.sector_count), 32'(want.sector_count));
          if (rsp_ch.hit !== want.hit)
            report("hit", 32'(rsp_ch.hit), 32'(want.hit));
          if (rsp_ch.last !== want.last)
            report("last", 32'(rsp_ch.last), 32'(want.last));
        end
        results_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: falling edge. Hold the payload until its transfer, then
  // advance to the next queued access. Requests go out in bursts of random
  // length; some bursts are followed by gaps, others by none.
  // ---------------------------------------------------------------------------
  int burst_left = 4;
  int gap_left = 0;

  always @(negedge clk) begin
    cache_access_t item;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fired) begin
      if (gap_left != 0 || access_queue.size() == 0) begin
        req_ch.valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        item = access_queue.pop_front();
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= item.mode;
        req_ch.block_number <= item.block_number;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response sink: walk a 16-bit ready pattern, reloaded whenever the 7-bit reload counter wraps.
  // Bit 0 is always set so a stall never lasts past one pattern pass.
  // ---------------------------------------------------------------------------
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  pattern_pos = '0;
  logic [6:0]  reload_count = '0;

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ready_pattern[pattern_pos];
      pattern_pos = pattern_pos + 4'd1;
      reload_count = reload_count + 7'd1;
      if (reload_count == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = 16'hFFFF;                                // no stalls
          1: ready_pattern = 16'($urandom) | 16'h0001;                // random
          2: ready_pattern = 16'($urandom | $urandom) | 16'h0001;     // light stalls
          default: ready_pattern = 16'($urandom & $urandom) | 16'h0001; // heavy stalls
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_access(logic [MODE_W-1:0] mode, logic [BLK_W-1:0] blk);
    cache_access_t a;
    a.mode = mode;
    a.block_number = blk;
    access_queue.push_back(a);
    items_queued++;
  endtask

  // Wait until every queued access has transferred and every result has come.
  task automatic wait_idle();
    do @(negedge clk);
    while (items_taken != items_queued || pending_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Write the block size register; the engine must be idle.
  task automatic write_spb(logic [SPB_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.blk_sectors <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    spb_shadow = value;
    n_sizes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Working set a little larger than the cache: hits, misses and evictions.
  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(0, 3))
        0: block_pool[i] = $urandom_range(0, 63);
        1: block_pool[i] = 32'hFFFF_FFFF - $urandom_range(0, 63);
        default: block_pool[i] = $urandom;
      endcase
    end
  endtask

  task automatic queue_random(int count);
    int pick;
    logic [MODE_W-1:0] mode;
    logic [BLK_W-1:0] blk;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      mode = (pick < 44) ? MODE_READ : (pick < 84) ? MODE_WRITE :
             (pick < 93) ? MODE_FLUSH : MODE_SPARE;
      blk = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                        : block_pool[$urandom_range(0, POOL_SIZE - 1)];
      queue_access(mode, blk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [SPB_W-1:0] size_plan [6];

  initial begin
    // Drive every block input to a known level from time zero.
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_READ;
    req_ch.block_number = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.blk_sectors = SPB_RESET;

    for (int i = 0; i < ENTRIES; i++) begin
      line_tag[i] = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_stamp[i] = '0;
    end
    access_tick = '0;
    spb_shadow = SPB_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset block size: cold miss, hit, write miss and
    // write hit at both ends of the block range, the unused mode, a flush with
    // dirty lines and one with none, then fill every line and evict two clean
    // lines, and flush the many dirty lines left.
    queue_access(MODE_READ, 32'h0000_0000);
    queue_access(MODE_READ, 32'h0000_0000);
    queue_access(MODE_WRITE, 32'hFFFF_FFFF);
    queue_access(MODE_WRITE, 32'h0000_0000);
    queue_access(MODE_SPARE, 32'hFFFF_FFFF);
    queue_access(MODE_FLUSH, 32'hFFFF_FFFF);
    queue_access(MODE_FLUSH, 32'h0000_0000);
    queue_access(MODE_READ, 32'hFFFF_FFFF);
    queue_access(MODE_WRITE, 32'hAAAA_AAAA);
    queue_access(MODE_WRITE, 32'h5555_5555);
    for (int i = 0; i < 12; i++) queue_access(MODE_WRITE, 32'h100 + i);
    queue_access(MODE_READ, 32'h1234_5678);
    queue_access(MODE_WRITE, 32'h0BAD_F00D);
    queue_access(MODE_FLUSH, 32'h0000_0000);
    wait_idle();

    // Random part across block sizes: both legal extremes, zero and values
    // above the legal range (clamped by the engine), and one in between.
    size_plan[0] = SPB_MIN;
    size_plan[1] = SPB_MAX;
    size_plan[2] = 8'd0;
    size_plan[3] = 8'd255;
    size_plan[4] = 8'd129;
    size_plan[5] = 8'($urandom_range(2, 127));
    for (int p = 0; p < 6; p++) begin
      write_spb(size_plan[p]);
      refill_pool();
      queue_random(PHASE_ITEMS / 2);
      // Hold new requests until every outstanding result has drained.
      if (p == 2) wait_idle();
      queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      wait_idle();
    end

    repeat (40) @(negedge clk);

    $display("Covered %0d accesses (%0d reads, %0d writes, %0d flushes, %0d unused)",
             items_taken, n_reads, n_writes, n_flushes, n_spare);
    $display("over %0d block sizes; checked %0d results: %0d hits, %0d write-backs, %0d fills.",
             n_sizes, results_seen, n_hits, n_writebacks, n_fills);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
